FILE: rtl/tsl_pkg.sv
// Package for the token splitter with line comments.
// Holds character constants, the character class functions and the result type.
// Used by token_splitter_line_comments and the testbench; depends on nothing else.
package tsl_pkg;

   // Character codes that steer the scanner.
   localparam logic [7:0] SlashChar = 8'h2F;
   localparam logic [7:0] SpaceChar = 8'h20;
   localparam logic [7:0] EqualChar = 8'h3D;
   localparam logic [7:0] TabChar   = 8'h09;
   localparam logic [7:0] CrChar    = 8'h0D;
   localparam logic [7:0] LfChar    = 8'h0A;
   localparam logic [7:0] CommaChar = 8'h2C;
   localparam logic [7:0] SemiChar  = 8'h3B;
   localparam logic [7:0] QuoteChar = 8'h22;

   // Entries in the result queue behind the scanner.
   localparam int QueueDepth = 4;

   // One result: a token character and its end-of-token mark.
   typedef struct packed {
      logic [7:0] token_char;
      logic       token_last;
   } token_result_type;

   // True for a byte that separates tokens.
   function automatic logic is_separator(input logic [7:0] c);
      return (c == SpaceChar) || (c == EqualChar) || (c == TabChar) ||
             (c == CrChar) || (c == LfChar) || (c == CommaChar) ||
             (c == SemiChar) || (c == QuoteChar);
   endfunction

   // True for a byte that ends a line comment.
   function automatic logic is_line_end(input logic [7:0] c);
      return (c == CrChar) || (c == LfChar);
   endfunction

endpackage

FILE: rtl/token_splitter_line_comments.sv
// Top level of the token splitter with line comments.
// Holds the scanner state, its next-state logic and the result queue.
// Depends on tsl_pkg.
//
// Usage:
//   The request channel (req_valid, req_stall, req_in_byte, req_final_byte)
//   takes one byte of a text buffer per transfer; req_final_byte marks the
//   last byte of the buffer and flushes what is held, but a third result waits.
//   The response channel (rsp_valid, rsp_stall, rsp_token_char,
//   rsp_token_last) delivers one token character per transfer, with
//   rsp_token_last high on the character that ends its token.
//   Throughput: one byte per cycle while req_stall is low. A byte causes
//   zero, one or two results; the response side moves one result per cycle
//   unless rsp_stall is high, and so sets the sustained rate when bytes cause
//   two results. Results are queued on transfer and offered in order.
//   A four-entry result queue decouples the channels; req_stall is high while
//   it holds more than two entries, so a stalled receiver backs up into the
//   request side once three or four results are pending.
//   Reset (synchronous, active high) empties the queue and puts the scanner
//   between tokens with nothing held.
module token_splitter_line_comments
   import tsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_last
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [CntWidth-1:0] StallLevel = CntWidth'(QueueDepth - 2);

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_TOKEN   = 2'd1,
      MODE_COMMENT = 2'd2,
      MODE_FLUSH   = 2'd3
   } scan_mode_type;

   // Scanner state.
   scan_mode_type scan_mode_ff, scan_mode_in;
   logic          slash_pending_ff, slash_pending_in;
   logic          held_valid_ff, held_valid_in;
   logic [7:0]    held_char_ff, held_char_in;

   // Result queue.
   token_result_type           queue_mem [QueueDepth];
   logic [PtrWidth-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]        count_ff, count_in;

   logic             req_accept;
   logic             rsp_accept;
   logic [1:0]       res_count;
   token_result_type res [2];
   logic             flush_due;

   assign req_stall  = (count_ff > StallLevel);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_token_char = queue_mem[rd_ptr_ff].token_char;
   assign rsp_token_last = queue_mem[rd_ptr_ff].token_last;

   // Scanner step for one byte: next state and up to two results.
   always_comb begin
      scan_mode_in     = scan_mode_ff;
      slash_pending_in = slash_pending_ff;
      held_valid_in    = held_valid_ff;
      held_char_in     = held_char_ff;
      res_count        = 2'd0;
      res[0]           = '0;
      res[1]           = '0;
      flush_due        = 1'b0;

      // A character owed from the previous final byte goes out first.
      if (scan_mode_in == MODE_FLUSH) begin
         res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b1};
         res_count         = res_count + 2'd1;
         held_valid_in     = 1'b0;
         slash_pending_in  = 1'b0;
         scan_mode_in      = MODE_BETWEEN;
      end

      if (scan_mode_in == MODE_COMMENT) begin
         // Inside a comment only a line end matters.
         held_valid_in    = 1'b0;
         slash_pending_in = 1'b0;
         if (is_line_end(req_in_byte)) begin
            scan_mode_in = MODE_BETWEEN;
         end
      end else if (slash_pending_in) begin
         // The byte after a slash decides what the slash was.
         slash_pending_in = 1'b0;
         if (req_in_byte == SlashChar) begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b1};
               res_count         = res_count + 2'd1;
            end
            held_valid_in = 1'b0;
            scan_mode_in  = MODE_COMMENT;
         end else if (is_separator(req_in_byte)) begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b0};
               res_count         = res_count + 2'd1;
            end
            res[res_count[0]] = '{token_char: SlashChar, token_last: 1'b1};
            res_count         = res_count + 2'd1;
            held_valid_in     = 1'b0;
            scan_mode_in      = MODE_BETWEEN;
         end else begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b0};
               res_count         = res_count + 2'd1;
            end
            res[res_count[0]] = '{token_char: SlashChar, token_last: 1'b0};
            res_count         = res_count + 2'd1;
            held_char_in      = req_in_byte;
            held_valid_in     = 1'b1;
            scan_mode_in      = MODE_TOKEN;
         end
      end else begin
         // Plain scanning between or inside tokens.
         if (req_in_byte == SlashChar) begin
            slash_pending_in = 1'b1;
         end else if (is_separator(req_in_byte)) begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b1};
               res_count         = res_count + 2'd1;
            end
            held_valid_in = 1'b0;
            scan_mode_in  = MODE_BETWEEN;
         end else begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b0};
               res_count         = res_count + 2'd1;
            end
            held_char_in  = req_in_byte;
            held_valid_in = 1'b1;
            scan_mode_in  = MODE_TOKEN;
         end
      end

      // The final byte flushes what is held; a third owed character waits.
      if (req_final_byte) begin
         if (slash_pending_in) begin
            if (held_valid_in) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b0};
               res_count         = res_count + 2'd1;
            end
            res[res_count[0]] = '{token_char: SlashChar, token_last: 1'b1};
            res_count         = res_count + 2'd1;
         end else if (held_valid_in) begin
            if (res_count < 2'd2) begin
               res[res_count[0]] = '{token_char: held_char_in, token_last: 1'b1};
               res_count         = res_count + 2'd1;
            end else begin
               flush_due = 1'b1;
            end
         end
         slash_pending_in = 1'b0;
         if (flush_due) begin
            scan_mode_in = MODE_FLUSH;
         end else begin
            held_valid_in = 1'b0;
            scan_mode_in  = MODE_BETWEEN;
         end
      end
   end

   // Queue pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(res_count);
         count_in  = count_in + CntWidth'(res_count);
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
         count_in  = count_in - CntWidth'(1);
      end
   end

   // Control and scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff     <= MODE_BETWEEN;
         slash_pending_ff <= 1'b0;
         held_valid_ff    <= 1'b0;
         held_char_ff     <= 8'h00;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (req_accept) begin
            scan_mode_ff     <= scan_mode_in;
            slash_pending_ff <= slash_pending_in;
            held_valid_ff    <= held_valid_in;
            held_char_ff     <= held_char_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: up to two results written per transfer.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (res_count != 2'd0) begin
            queue_mem[wr_ptr_ff] <= res[0];
         end
         if (res_count == 2'd2) begin
            queue_mem[wr_ptr_ff + PtrWidth'(1)] <= res[1];
         end
      end
   end

   // The queue never overflows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(QueueDepth))
      else $error("result queue overflow");

   // A transfer is only taken when two entries are free.
   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (count_ff <= StallLevel))
      else $error("byte taken without room for two results");

   // After a final byte no slash is left pending.
   a_final_clears_slash: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_final_byte) |=> !slash_pending_ff)
      else $error("slash pending after final byte");

   // A flush due always has a held character behind it.
   a_flush_has_char: assert property (@(posedge clock) disable iff (reset)
      (scan_mode_ff == MODE_FLUSH) |-> held_valid_ff)
      else $error("flush due without held character");

endmodule

FILE: dv/tb.sv
// Testbench for token_splitter_line_comments: directed and random byte streams with idling.
// A scoreboard class predicts every token character and checks each response transfer.
// Depends on rtl/tsl_pkg.sv and rtl/token_splitter_line_comments.sv.
`timescale 1ns / 100ps

module tb
   import tsl_pkg::*;
;

   // Scanner modes of the predictor.
   typedef enum logic [1:0] {
      ScanBetween,
      ScanToken,
      ScanComment,
      ScanFlush
   } scan_mode_type;

   // Scoreboard: tracks the tokenizer state and the characters still owed.
   class token_tracker;
      scan_mode_type    mode;
      bit               slash_waiting;
      bit               char_held;
      logic [7:0]       held_byte;
      int               emitted_now;
      int               mismatches;
      token_result_type owed_chars[$];

      function new();
         mode          = ScanBetween;
         slash_waiting = 1'b0;
         char_held     = 1'b0;
         held_byte     = 8'h00;
         mismatches    = 0;
      endfunction

      function int pending();
         return owed_chars.size();
      endfunction

      function void note_failure(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: %s", what);
         end
      endfunction

      // Bytes that split tokens.
      function bit splits_token(logic [7:0] c);
         case (c)
            SpaceChar, EqualChar, TabChar, CrChar, LfChar, CommaChar, SemiChar, QuoteChar:
               return 1'b1;
            default:
               return 1'b0;
         endcase
      endfunction

      function bit ends_line(logic [7:0] c);
         return (c == CrChar) || (c == LfChar);
      endfunction

      function void owe(logic [7:0] c, logic last);
         token_result_type r;
         r.token_char = c;
         r.token_last = last;
         owed_chars.push_back(r);
         emitted_now++;
      endfunction

      // Advance the tokenizer by one accepted byte and queue what it emits.
      function void note_byte(logic [7:0] b, logic fin);
         emitted_now = 0;
         // A character owed from the last final byte goes out first.
         if (mode == ScanFlush) begin
            owe(held_byte, 1'b1);
            char_held     = 1'b0;
            slash_waiting = 1'b0;
            mode          = ScanBetween;
         end

         if (mode == ScanComment) begin
            char_held     = 1'b0;
            slash_waiting = 1'b0;
            if (ends_line(b)) begin
               mode = ScanBetween;
            end
         end else if (slash_waiting) begin
            slash_waiting = 1'b0;
            if (b == SlashChar) begin
               // Two slashes: the comment closes any open token.
               if (char_held) begin
                  owe(held_byte, 1'b1);
               end
               char_held = 1'b0;
               mode      = ScanComment;
            end else if (splits_token(b)) begin
               if (char_held) begin
                  owe(held_byte, 1'b0);
               end
               owe(SlashChar, 1'b1);
               char_held = 1'b0;
               mode      = ScanBetween;
            end else begin
               if (char_held) begin
                  owe(held_byte, 1'b0);
               end
               owe(SlashChar, 1'b0);
               held_byte = b;
               char_held = 1'b1;
               mode      = ScanToken;
            end
         end else begin
            if (b == SlashChar) begin
               slash_waiting = 1'b1;
            end else if (splits_token(b)) begin
               if (char_held) begin
                  owe(held_byte, 1'b1);
               end
               char_held = 1'b0;
               mode      = ScanBetween;
            end else begin
               if (char_held) begin
                  owe(held_byte, 1'b0);
               end
               held_byte = b;
               char_held = 1'b1;
               mode      = ScanToken;
            end
         end

         // The final byte flushes everything held, unless two results are already out.
         if (fin) begin
            if (slash_waiting) begin
               if (char_held) begin
                  owe(held_byte, 1'b0);
               end
               owe(SlashChar, 1'b1);
            end else if (char_held) begin
               if (emitted_now < 2) begin
                  owe(held_byte, 1'b1);
               end else begin
                  slash_waiting = 1'b0;
                  mode          = ScanFlush;
                  return;
               end
            end
            slash_waiting = 1'b0;
            char_held     = 1'b0;
            mode          = ScanBetween;
         end
      endfunction

      // Compare one response transfer with the oldest owed character.
      function void check_char(logic [7:0] c, logic last);
         token_result_type e;
         if (owed_chars.size() == 0) begin
            note_failure($sformatf("unexpected char %02h last %0b", c, last));
            return;
         end
         e = owed_chars.pop_front();
         if (e.token_char !== c || e.token_last !== last) begin
            note_failure($sformatf("expected char %02h last %0b, got char %02h last %0b",
                                   e.token_char, e.token_last, c, last));
         end
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_token_char;
   logic       rsp_token_last;

   token_tracker tracker = new();

   int  bytes_sent   = 0;
   int  burst_left   = 0;
   bit  sender_idles = 1'b1;
   int  stall_style  = 0;
   int  stall_cycle  = 0;

   token_splitter_line_comments u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_char (rsp_token_char),
      .rsp_token_last (rsp_token_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watch both channels; results are checked before the new byte is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tracker.check_char(rsp_token_char, rsp_token_last);
         end
         if (req_valid && !req_stall) begin
            tracker.note_byte(req_in_byte, req_final_byte);
         end
      end
   end

   // Receiver stall pattern in one of four styles, which the stall_cycle counter redraws.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 150 == 0) begin
            stall_style <= $urandom_range(0, 3);
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ((stall_cycle % 7) < 3);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Offer one byte at a falling edge and wait for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (sender_idles && burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit fin_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], fin_at_end && (i == s.len() - 1));
      end
   endtask

   // Random stream byte; now and then it ends the buffer.
   task automatic send_stream_byte(input logic [7:0] b);
      send_byte(b, $urandom_range(0, 39) == 0);
   endtask

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 7))
         0: return SpaceChar;
         1: return EqualChar;
         2: return TabChar;
         3: return CrChar;
         4: return LfChar;
         5: return CommaChar;
         6: return SemiChar;
         default: return QuoteChar;
      endcase
   endfunction

   function automatic logic [7:0] pick_token_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         return 8'($urandom_range(8'h61, 8'h7A));
      end else if (r < 8) begin
         return SlashChar;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // One piece of text: a token, a separator, a comment, a lone slash or noise.
   task automatic send_fragment();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         len = $urandom_range(1, 8);
         repeat (len) send_stream_byte(pick_token_byte());
      end else if (kind < 70) begin
         send_stream_byte(pick_separator());
      end else if (kind < 82) begin
         send_stream_byte(SlashChar);
         send_stream_byte(SlashChar);
         len = $urandom_range(0, 6);
         repeat (len) send_stream_byte(8'($urandom_range(0, 255)));
         send_stream_byte(($urandom_range(0, 1) == 0) ? CrChar : LfChar);
      end else if (kind < 90) begin
         send_stream_byte(SlashChar);
      end else begin
         send_stream_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Hold the sender off until every owed character has arrived, with a limit.
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0 && guard < 2000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Held character, pending slash and an ordinary final byte all owed at once.
      send_text("ab/c", 1'b1);
      // Slash at the end of the buffer; this byte also collects the owed character.
      send_text("x/", 1'b1);
      // Comment straight after a token, then one between tokens.
      send_text("a//q", 1'b0);
      send_byte(LfChar, 1'b0);
      send_text("//z", 1'b0);
      send_byte(CrChar, 1'b0);
      // NUL and all-ones bytes are token characters; slash before a separator.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(SlashChar, 1'b0);
      send_byte(EqualChar, 1'b0);
      // Remaining separators, ending the buffer on a separator.
      send_text("p\tq,r;s\"", 1'b1);
      wait_for_drain();

      // Random phases; the second runs without sender gaps.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idles = (phase != 1);
         while (bytes_sent < 27 + (phase + 1) * 430) begin
            send_fragment();
         end
         wait_for_drain();
      end
      sender_idles = 1'b1;

      // A closing separator clears any character still owed.
      send_byte(SpaceChar, 1'b1);
      wait_for_drain();
      repeat (8) @(negedge clock);
      if (tracker.pending() != 0) begin
         tracker.note_failure($sformatf("%0d characters never arrived", tracker.pending()));
      end

      if (tracker.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #1000000;
      $display("status: fail");
      $finish;
   end

endmodule
